FILE: rtl/tcw_pkg.sv
// shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int COLOUT_W = 7;
  localparam int ROWOUT_W = 5;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_cmd_if.sv
// command channel: opcode, character and cell index
`default_nettype none

interface tcw_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OPCODE_W-1:0]  opcode;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::INDEX_W-1:0]   cell_index;

  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink (input valid, opcode, char_code, cell_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_rsp_if.sv
// response channel: cursor, scroll flag and read data
`default_nettype none

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::COLOUT_W-1:0]  cursor_column;
  logic [tcw_pkg::ROWOUT_W-1:0]  cursor_row;
  logic                          scrolled;
  logic [tcw_pkg::CELL_W-1:0]    read_entry;

  modport source (output valid, cursor_column, cursor_row, scrolled, read_entry, input ready);
  modport sink (input valid, cursor_column, cursor_row, scrolled, read_entry, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_screen.sv
// screen cell store: one write port, one registered read port
`default_nettype none

module tcw_screen #(
  parameter int  DEPTH  = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire                           clk,
  input  wire  tcw_pkg::mem_ctl_t       ctl,
  input  wire  [ADDR_W-1:0]             waddr,
  input  wire  [tcw_pkg::CELL_W-1:0]    wdata,
  input  wire  [ADDR_W-1:0]             raddr,
  output logic [tcw_pkg::CELL_W-1:0]    rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_writer.sv
// text console writer top level: cursor sequencer, register port and screen store
//
// A put of an ordinary character, newline, return or tab goes from accept to the
// done state and then to the response register; a read also passes the registered
// read port of the cell store and the read state. A put that scrolls copies every
// line up one cell per cycle through the single read and write port of the store
// and then blanks the bottom line. A clear writes blanks to every cell, one per
// cycle. The command channel is not ready while an item is in work; a finished
// result sits in the response register until taken, and the next command is
// accepted meanwhile. The cell store is not cleared after reset: issue a clear
// before reading cells. Colors are written at byte addresses 0 (foreground) and 4
// (background) and take effect for cells written afterwards.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [tcw_pkg::PADDR_W-1:0]    paddr,
  input  wire  [tcw_pkg::PDATA_W-1:0]    pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  tcw_cmd_if.sink                        cmd,
  tcw_rsp_if.source                      rsp
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int PH_W      = $clog2(TAB_STOP);
  localparam int COPY_LAST = COLUMNS * (ROWS - 1) - 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                    state;
  logic [COL_W-1:0]              cur_col;
  logic [ROW_W-1:0]              cur_line;
  logic [PH_W-1:0]               cur_ph;
  logic [tcw_pkg::COLOR_W-1:0]   fg;
  logic [tcw_pkg::COLOR_W-1:0]   bg;
  logic [ADDR_W-1:0]             cnt;
  logic                          copy_wr;
  logic [ADDR_W-1:0]             copy_addr;
  logic                          rd_hit;
  logic                          scrolled_p;
  logic [tcw_pkg::CELL_W-1:0]    entry_p;

  logic                          accept;
  logic                          slot_free;
  logic                          fill_go;
  logic [7:0]                    attr;
  logic [tcw_pkg::CELL_W-1:0]    blank;
  logic [COL_W-1:0]              col_next;
  logic [ROW_W-1:0]              line_next;
  logic [PH_W-1:0]               ph_next;
  logic                          scroll_next;
  logic                          put_wr;
  logic                          read_in_range;
  logic [ADDR_W-1:0]             put_addr;
  tcw_pkg::mem_ctl_t             mctl;
  logic [ADDR_W-1:0]             waddr;
  logic [tcw_pkg::CELL_W-1:0]    wdata;
  logic [ADDR_W-1:0]             raddr;
  logic [tcw_pkg::CELL_W-1:0]    rdata;

  // register port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      tcw_pkg::REG_FG: prdata = tcw_pkg::PDATA_W'(fg);
      tcw_pkg::REG_BG: prdata = tcw_pkg::PDATA_W'(bg);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FG_RESET;
      bg <= tcw_pkg::BG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        tcw_pkg::REG_FG: fg <= pwdata[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::REG_BG: bg <= pwdata[tcw_pkg::COLOR_W-1:0];
        default:         fg <= fg;
      endcase
    end
  end

  assign attr  = {bg, fg};
  assign blank = {attr, tcw_pkg::CH_BLANK};

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !rsp.valid || rsp.ready;
  assign fill_go   = (state == S_FILL) && !copy_wr;

  // cursor step for a put
  always_comb begin
    col_next    = cur_col;
    line_next   = cur_line;
    ph_next     = cur_ph;
    put_wr      = 1'b0;
    scroll_next = 1'b0;
    case (cmd.char_code)
      tcw_pkg::CH_NEWLINE: begin
        col_next  = '0;
        ph_next   = '0;
        line_next = cur_line + ROW_W'(1);
      end
      tcw_pkg::CH_RETURN: begin
        col_next = '0;
        ph_next  = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_next = cur_col + COL_W'(TAB_STOP) - COL_W'(cur_ph);
        ph_next  = '0;
      end
      default: begin
        put_wr   = 1'b1;
        col_next = cur_col + COL_W'(1);
        ph_next  = (cur_ph == PH_W'(TAB_STOP - 1)) ? '0 : cur_ph + PH_W'(1);
      end
    endcase
    if (32'(col_next) >= COLUMNS) begin
      col_next  = '0;
      ph_next   = '0;
      line_next = line_next + ROW_W'(1);
    end
    if (32'(line_next) >= ROWS) begin
      scroll_next = 1'b1;
      line_next   = ROW_W'(ROWS - 1);
    end
  end

  assign put_addr      = ADDR_W'(32'(cur_line) * COLUMNS + 32'(cur_col));
  assign read_in_range = 32'(cmd.cell_index) < CELLS;

  // store port selection
  always_comb begin
    mctl.wr_en = 1'b0;
    waddr      = put_addr;
    wdata      = {attr, cmd.char_code};
    if (copy_wr) begin
      mctl.wr_en = 1'b1;
      waddr      = copy_addr;
      wdata      = rdata;
    end else if (fill_go) begin
      mctl.wr_en = 1'b1;
      waddr      = cnt;
      wdata      = blank;
    end else if (accept && cmd.opcode == tcw_pkg::OP_PUT && put_wr) begin
      mctl.wr_en = 1'b1;
    end
    if (state == S_COPY) begin
      raddr      = cnt + ADDR_W'(COLUMNS);
      mctl.rd_en = 1'b1;
    end else begin
      raddr      = ADDR_W'(cmd.cell_index);
      mctl.rd_en = accept && cmd.opcode == tcw_pkg::OP_READ && read_in_range;
    end
  end

  tcw_screen #(
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .ctl   (mctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_col  <= '0;
      cur_line <= '0;
      cur_ph   <= '0;
      copy_wr  <= 1'b0;
    end else begin
      copy_wr <= (state == S_COPY);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.opcode)
              tcw_pkg::OP_PUT: begin
                cur_col  <= col_next;
                cur_line <= line_next;
                cur_ph   <= ph_next;
                state    <= scroll_next ? S_COPY : S_DONE;
              end
              tcw_pkg::OP_CLEAR: begin
                cur_col  <= '0;
                cur_line <= '0;
                cur_ph   <= '0;
                state    <= S_FILL;
              end
              tcw_pkg::OP_READ: state <= S_READ;
              default:          state <= S_DONE;
            endcase
          end
        end
        S_COPY: begin
          if (32'(cnt) == COPY_LAST) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_go && 32'(cnt) == CELLS - 1) begin
            state <= S_DONE;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    copy_addr <= cnt;
    if (accept) begin
      cnt        <= '0;
      rd_hit     <= read_in_range;
      entry_p    <= '0;
      scrolled_p <= (cmd.opcode == tcw_pkg::OP_PUT) && scroll_next;
    end else if (state == S_COPY || fill_go) begin
      cnt <= cnt + ADDR_W'(1);
    end
    if (state == S_READ) begin
      entry_p <= rd_hit ? rdata : '0;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      rsp.cursor_column <= tcw_pkg::COLOUT_W'(cur_col);
      rsp.cursor_row    <= tcw_pkg::ROWOUT_W'(cur_line);
      rsp.scrolled      <= scrolled_p;
      rsp.read_entry    <= entry_p;
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> 32'(cur_col) < COLUMNS && 32'(cur_line) < ROWS)
    else $error("cursor left the screen");

  a_tab_phase_home: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && cur_col == '0 |-> cur_ph == '0)
    else $error("tab phase out of step with column");

  a_scroll_bottom_row: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && scrolled_p |-> 32'(cur_line) == ROWS - 1)
    else $error("scroll did not leave cursor on bottom row");

  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY && copy_wr |-> raddr != copy_addr)
    else $error("scroll copy reads the cell it writes");

  a_fill_after_copy: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL && $past(state) == S_COPY |-> copy_wr && 32'(cnt) == COPY_LAST + 1)
    else $error("blank fill started at the wrong cell");

endmodule

`default_nettype wire

FILE: tb/console_checker.sv
// checker for the text console writer: tracks screen, cursor and colors and checks each response
module console_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  tcw_cmd_if                 cmd,
  tcw_rsp_if                 rsp,
  output int                 failures,
  output int                 outstanding,
  output int                 responses,
  output int                 scrolls,
  output int                 reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [COLOUT_W-1:0] column;
    logic [ROWOUT_W-1:0] row;
    logic                scrolled;
    logic [CELL_W-1:0]   entry;
  } console_view_t;

  logic [CELL_W-1:0]  screen [CELLS];
  int                 cur_col;
  int                 cur_row;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  console_view_t      expected_views [$];

  function automatic logic [CELL_W-1:0] blank_cell();
    return {bg, fg, CH_BLANK};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
    cur_row = ROWS - 1;
  endfunction

  function automatic console_view_t apply_command(logic [OPCODE_W-1:0] op,
                                                 logic [CHAR_W-1:0] ch,
                                                 logic [INDEX_W-1:0] idx);
    console_view_t v;
    v = '0;
    if (op == OP_PUT) begin
      if (ch == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (ch == CH_RETURN) begin
        cur_col = 0;
      end else if (ch == CH_TAB) begin
        cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
      end else begin
        if (cur_row * COLUMNS + cur_col < CELLS) screen[cur_row * COLUMNS + cur_col] = {bg, fg, ch};
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        scroll_screen();
        v.scrolled = 1'b1;
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
      cur_col = 0;
      cur_row = 0;
    end else if (op == OP_READ) begin
      if (idx < CELLS) v.entry = screen[idx];
    end
    v.column = COLOUT_W'(cur_col);
    v.row    = ROWOUT_W'(cur_row);
    return v;
  endfunction

  function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                      logic [CELL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    console_view_t want;
    if (rst) begin
      cur_col = 0;
      cur_row = 0;
      fg = FG_RESET;
      bg = BG_RESET;
      expected_views.delete();
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_FG) fg = pwdata[COLOR_W-1:0];
        else if (paddr[PADDR_W-1:2] == REG_BG) bg = pwdata[COLOR_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        responses++;
        if (rsp.scrolled === 1'b1) scrolls++;
        if (expected_views.size() == 0) begin
          $error("response beat with no command outstanding");
          failures++;
        end else begin
          want = expected_views.pop_front();
          check_field("cursor_column", CELL_W'(want.column), CELL_W'(rsp.cursor_column));
          check_field("cursor_row", CELL_W'(want.row), CELL_W'(rsp.cursor_row));
          check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(rsp.scrolled));
          check_field("read_entry", want.entry, rsp.read_entry);
        end
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.opcode == OP_READ) reads++;
        expected_views.push_back(apply_command(cmd.opcode, cmd.char_code, cmd.cell_index));
      end
      outstanding = expected_views.size();
    end
  end

endmodule

FILE: tb/tb_text_console_writer.sv
// testbench top for the text console writer: stimulus, color setup, watchdog and verdict
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASES          = 5;
  localparam int PHASE_ITEMS     = 245;
  localparam int STEADY_ITEMS    = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT  = 20000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int failures;
  int outstanding;
  int responses;
  int scrolls;
  int reads;
  int items_sent;
  int color_writes;
  int idle_cycles;
  bit hold_off_req;
  bit steady;

  tcw_cmd_if cmd ();
  tcw_rsp_if rsp ();

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cmd    (cmd),
    .rsp    (rsp)
  );

  console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .cmd        (cmd),
    .rsp        (rsp),
    .failures   (failures),
    .outstanding(outstanding),
    .responses  (responses),
    .scrolls    (scrolls),
    .reads      (reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    if ($urandom_range(0, 19) == 0) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic send(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                      input logic [INDEX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid      = 1'b1;
    cmd.opcode     = op;
    cmd.char_code  = ch;
    cmd.cell_index = idx;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    cmd.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_color(input logic sel, input logic [COLOR_W-1:0] color);
    paddr   = {sel, 2'b00};
    pwdata  = ($urandom() & ~32'hF) | PDATA_W'(color);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    color_writes++;
  endtask

  // receive side: random stalls, one long hold-off on request, none while steady
  initial begin : receiver
    int r;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (steady) begin
        rsp.ready = 1'b1;
        @(negedge clk);
      end else if (r < 65) begin
        rsp.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else if (r < 95) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(15, 60)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int phase_start;
    logic [INDEX_W-1:0] idx;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cmd.valid      = 1'b0;
    cmd.opcode     = OP_PUT;
    cmd.char_code  = '0;
    cmd.cell_index = '0;
    hold_off_req   = 1'b0;
    steady         = 1'b0;
    idle_cycles    = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: reset colors, every opcode, control characters, extreme fields
    send(OP_CLEAR, 8'hA5, 11'h555);
    send(OP_PUT, 8'h41, '0);
    send(OP_PUT, 8'h00, '1);
    send(OP_PUT, 8'hFF, '0);
    send(OP_PUT, 8'h80, '0);
    send(OP_PUT, CH_TAB, '0);
    send(OP_PUT, CH_TAB, '1);
    send(OP_PUT, 8'h7E, '0);
    send(OP_PUT, CH_RETURN, '0);
    send(OP_PUT, 8'h5A, '0);
    send(OP_PUT, CH_NEWLINE, '0);
    send(OP_READ, 8'hFF, 11'd0);
    send(OP_READ, 8'h00, 11'd2);
    send(OP_READ, 8'h00, 11'd3);
    send(OP_READ, 8'h00, 11'd16);
    send(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
    send(OP_READ, 8'h00, INDEX_W'(CELLS));
    send(OP_READ, 8'h00, '1);
    send(OP_UNUSED, 8'hFF, '1);
    send(OP_UNUSED, 8'h00, '0);
    send(OP_PUT, CH_BLANK, '0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_color(REG_FG, 4'h0);
          write_color(REG_BG, 4'h0);
        end
        1: begin
          write_color(REG_BG, 4'hF);
          write_color(REG_FG, 4'hF);
          hold_off_req = 1'b1;
        end
        default: begin
          write_color(REG_FG, COLOR_W'($urandom()));
          write_color(REG_BG, COLOR_W'($urandom()));
        end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        steady = (p == 2) && (items_sent < phase_start + STEADY_ITEMS);
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          // a line of text, usually closed by a newline
          n = $urandom_range(1, 60);
          repeat (n) send(OP_PUT, text_char(), INDEX_W'($urandom()));
          n = $urandom_range(0, 9);
          if (n < 7) send(OP_PUT, CH_NEWLINE, INDEX_W'($urandom()));
          else if (n < 8) send(OP_PUT, CH_RETURN, INDEX_W'($urandom()));
        end else if (kind < 65) begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) send(OP_PUT, text_char(), INDEX_W'($urandom()));
            send(OP_PUT, CH_TAB, INDEX_W'($urandom()));
          end
        end else if (kind < 72) begin
          n = $urandom_range(3, 30);
          repeat (n) send(OP_PUT, CH_NEWLINE, INDEX_W'($urandom()));
        end else if (kind < 87) begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) idx = INDEX_W'($urandom_range(0, CELLS - 1));
            else if (kind < 8) idx = INDEX_W'($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
            else idx = INDEX_W'($urandom());
            send(OP_READ, CHAR_W'($urandom()), idx);
          end
        end else if (kind < 90) begin
          send(OP_CLEAR, CHAR_W'($urandom()), INDEX_W'($urandom()));
        end else if (kind < 93) begin
          send(OP_UNUSED, CHAR_W'($urandom()), INDEX_W'($urandom()));
        end else begin
          n = $urandom_range(1, 5);
          repeat (n) send(OPCODE_W'($urandom()), CHAR_W'($urandom()), INDEX_W'($urandom()));
        end
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run covered %0d commands (%0d cell reads), %0d responses checked, %0d scrolls",
             items_sent, reads, responses, scrolls);
    $display("color registers written %0d times over %0d color settings",
             color_writes, PHASES);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
